// ----- rtl/lpfd_pkg.sv -----
`default_nettype none
package lpfd_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int FNUM_W  = 4;
    localparam int ERR_W   = 3;
    localparam int FTOT_W  = 5;
    localparam int VAL_W   = 24;

    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TRAILER  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_WORD = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERRUN  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [FNUM_W-1:0] fnum;
        logic              last;
        logic [ERR_W-1:0]  err;
        logic [FTOT_W-1:0] ftot;
        logic [VAL_W-1:0]  plen;
    } lpfd_item_t;

endpackage
`default_nettype wire

// ----- rtl/lpfd_parse.sv -----
`default_nettype none
module lpfd_parse #(
    parameter int LEN_BYTES  = 4,
    parameter int MAX_FIELDS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 beat,
    input  wire logic [7:0]           data_byte,
    output logic                      push,
    output lpfd_pkg::lpfd_item_t      item
);
    import lpfd_pkg::*;

    localparam int POS_W = (LEN_BYTES > 2) ? 2 : 1;
    localparam int BUF_W = (LEN_BYTES - 1) * 8;
    localparam int FC_W  = $clog2(MAX_FIELDS + 1);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_WORD    = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;

    localparam logic [VAL_W-1:0] LEN_V   = VAL_W'(LEN_BYTES);
    localparam logic [VAL_W-1:0] MIN_TOT = VAL_W'(2 * LEN_BYTES);
    localparam logic [7:0]       CNT_MAX = 8'(LEN_BYTES - 1);

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [VAL_W-1:0] total_reg, total_next;
    logic [VAL_W-1:0] bpos_reg, bpos_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [FC_W-1:0]  fc_reg, fc_next;
    logic [ERR_W-1:0] err_reg, err_next;

    logic [VAL_W-1:0] bp_inc;
    logic             word_last;
    logic             word_bad;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] tot_sel;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] flen;
    logic [VAL_W:0]   reach;
    logic             overrun;
    logic [VAL_W-1:0] rem_dec;
    logic [FC_W-1:0]  fc_inc;
    logic             more;
    logic             finish;
    logic [ERR_W-1:0] fin_err;
    logic [VAL_W-1:0] fin_len;
    logic             after;
    logic [FC_W-1:0]  after_fc;

    assign bp_inc    = bpos_reg + 1'b1;
    assign word_last = (pos_reg == POS_W'(LEN_BYTES - 1));
    assign word_bad  = (data_byte > CNT_MAX);
    assign tot_sel   = (phase_reg == PH_HEADER) ? val : total_reg;
    assign limit     = tot_sel - LEN_V;
    assign flen      = val - LEN_V;
    assign reach     = {1'b0, bp_inc} + {1'b0, flen};
    assign overrun   = (reach > {1'b0, limit});
    assign rem_dec   = rem_reg - 1'b1;
    assign fc_inc    = fc_reg + 1'b1;
    assign more      = (bp_inc < limit);

    always_comb
    begin
        val = '0;
        for (int i = 0; i < LEN_BYTES - 1; i++)
        begin
            if (i < int'(data_byte))
            begin
                val[i*8 +: 8] = buf_reg[i*8 +: 8];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        buf_next   = buf_reg;
        total_next = total_reg;
        bpos_next  = bpos_reg;
        rem_next   = rem_reg;
        fc_next    = fc_reg;
        err_next   = err_reg;
        push       = 1'b0;
        finish     = 1'b0;
        fin_err    = ERR_NONE;
        fin_len    = total_reg;
        after      = 1'b0;
        after_fc   = fc_reg;
        item.kind  = KIND_BYTE;
        item.data  = data_byte;
        item.fnum  = FNUM_W'(fc_reg);
        item.last  = 1'b0;
        item.err   = ERR_NONE;
        item.ftot  = FTOT_W'(fc_reg);
        item.plen  = total_reg;

        if (beat)
        begin
            bpos_next = bp_inc;
            if (phase_reg == PH_HEADER || phase_reg == PH_WORD || phase_reg == PH_TRAILER)
            begin
                if (word_last)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    for (int i = 0; i < LEN_BYTES - 1; i++)
                    begin
                        if (pos_reg == POS_W'(i))
                        begin
                            buf_next[i*8 +: 8] = data_byte;
                        end
                    end
                end
            end

            case (phase_reg)
                PH_HEADER:
                begin
                    if (word_last)
                    begin
                        if (word_bad)
                        begin
                            finish  = 1'b1;
                            fin_err = ERR_BAD_WORD;
                            fin_len = '0;
                        end
                        else if (val < MIN_TOT)
                        begin
                            finish  = 1'b1;
                            fin_err = ERR_BAD_WORD;
                            fin_len = val;
                        end
                        else
                        begin
                            total_next = val;
                            after      = 1'b1;
                        end
                    end
                end
                PH_WORD:
                begin
                    if (word_last)
                    begin
                        if (word_bad || val < LEN_V || overrun)
                        begin
                            phase_next = PH_SKIP;
                            err_next   = (word_bad || val < LEN_V) ? ERR_BAD_WORD : ERR_OVERRUN;
                            if (bp_inc >= total_reg)
                            begin
                                finish  = 1'b1;
                                fin_err = err_next;
                            end
                        end
                        else if (val == LEN_V)
                        begin
                            push      = 1'b1;
                            item.kind = KIND_EMPTY;
                            fc_next   = fc_inc;
                            after     = 1'b1;
                            after_fc  = fc_inc;
                        end
                        else
                        begin
                            rem_next   = flen;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    push     = 1'b1;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        item.last = 1'b1;
                        fc_next   = fc_inc;
                        after     = 1'b1;
                        after_fc  = fc_inc;
                    end
                end
                PH_TRAILER:
                begin
                    if (word_last)
                    begin
                        finish  = 1'b1;
                        fin_err = word_bad ? ERR_BAD_WORD :
                                  ((val == total_reg) ? ERR_NONE : ERR_TRAILER);
                    end
                end
                PH_SKIP:
                begin
                    if (bp_inc >= total_reg)
                    begin
                        finish  = 1'b1;
                        fin_err = err_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                    total_next = '0;
                    bpos_next  = '0;
                    rem_next   = '0;
                    fc_next    = '0;
                    err_next   = ERR_NONE;
                end
            endcase

            if (after)
            begin
                if (more)
                begin
                    if (after_fc >= FC_W'(MAX_FIELDS))
                    begin
                        phase_next = PH_SKIP;
                        err_next   = ERR_TOO_MANY;
                    end
                    else
                    begin
                        phase_next = PH_WORD;
                    end
                end
                else
                begin
                    phase_next = PH_TRAILER;
                end
            end

            if (finish)
            begin
                push       = 1'b1;
                item.kind  = (fin_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
                item.err   = fin_err;
                item.plen  = fin_len;
                phase_next = PH_HEADER;
                pos_next   = '0;
                total_next = '0;
                bpos_next  = '0;
                rem_next   = '0;
                fc_next    = '0;
                err_next   = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            total_reg <= '0;
            bpos_reg  <= '0;
            rem_reg   <= '0;
            fc_reg    <= '0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            bpos_reg  <= bpos_next;
            rem_reg   <= rem_next;
            fc_reg    <= fc_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule
`default_nettype wire

// ----- rtl/lpfd_queue.sv -----
`default_nettype none
module lpfd_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lpfd_pkg::lpfd_item_t  push_item,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       nonempty,
    output lpfd_pkg::lpfd_item_t       head_item
);
    import lpfd_pkg::*;

    lpfd_item_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign nonempty  = (cnt_reg != '0);
    assign head_item = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && nonempty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lpfd_out.sv -----
`default_nettype none
module lpfd_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  avail,
    input  wire lpfd_pkg::lpfd_item_t  head_item,
    output logic                       pop,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [1:0]                 kind,
    output logic [7:0]                 payload_byte,
    output logic [3:0]                 field_number,
    output logic                       last_in_field,
    output logic [2:0]                 error_code,
    output logic [4:0]                 field_total,
    output logic [23:0]                packet_length
);
    import lpfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              is_field;
    logic              is_end;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] pay_reg;
    logic [FNUM_W-1:0] fnum_reg;
    logic              last_reg;
    logic [ERR_W-1:0]  err_reg;
    logic [FTOT_W-1:0] ftot_reg;
    logic [VAL_W-1:0]  plen_reg;

    assign pop        = avail && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);
    assign is_field   = (head_item.kind == KIND_BYTE) || (head_item.kind == KIND_EMPTY);
    assign is_end     = !is_field;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head_item.kind;
            pay_reg  <= (head_item.kind == KIND_BYTE) ? head_item.data : '0;
            fnum_reg <= is_field ? head_item.fnum : '0;
            last_reg <= (head_item.kind == KIND_BYTE) && head_item.last;
            err_reg  <= is_end ? head_item.err : ERR_NONE;
            ftot_reg <= is_end ? head_item.ftot : '0;
            plen_reg <= is_end ? head_item.plen : '0;
        end
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = pay_reg;
    assign field_number  = fnum_reg;
    assign last_in_field = last_reg;
    assign error_code    = err_reg;
    assign field_total   = ftot_reg;
    assign packet_length = plen_reg;

endmodule
`default_nettype wire

// ----- rtl/length_prefixed_field_deframer.sv -----
`default_nettype none
// Channel   Handshake             Payload
// in        in_valid / in_stall   data_byte
// out       out_valid / out_stall kind, payload_byte, field_number, last_in_field,
//                                 error_code, field_total, packet_length
//
// One byte a cycle unless stalled; a result is queued, then registered at the output.
// The parser's byte counter and field state are updated on each accepted byte.
// A four-entry queue sits between parser and output register.
// in_stall rises only while the queue is full; out_stall backs up into the queue.
// rst_n clears parser, queue and output valid at once.
module length_prefixed_field_deframer #(
    parameter int LEN_BYTES  = 4,
    parameter int MAX_FIELDS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [3:0]       field_number,
    output logic             last_in_field,
    output logic [2:0]       error_code,
    output logic [4:0]       field_total,
    output logic [23:0]      packet_length
);
    import lpfd_pkg::*;

    logic       q_full;
    logic       q_nonempty;
    logic       q_pop;
    logic       beat;
    logic       push;
    lpfd_item_t push_item;
    lpfd_item_t head_item;

    assign in_stall = q_full;
    assign beat     = in_valid && !q_full;

    lpfd_parse #(
        .LEN_BYTES  (LEN_BYTES),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .data_byte (data_byte),
        .push      (push),
        .item      (push_item)
    );

    lpfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head_item (head_item)
    );

    lpfd_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .avail         (q_nonempty),
        .head_item     (head_item),
        .pop           (q_pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .field_number  (field_number),
        .last_in_field (last_in_field),
        .error_code    (error_code),
        .field_total   (field_total),
        .packet_length (packet_length)
    );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;

    localparam int LEN_BYTES = 4;
    localparam int MAX_FIELDS = 16;
    localparam int BYTES_PER_ROUND = 375;
    localparam int ROUNDS = 4;
    localparam int SEND_IDLE [ROUNDS] = '{0, 77, 0, 27};
    localparam int RECV_STALL [ROUNDS] = '{0, 0, 77, 27};

    typedef enum logic [2:0] {
        AWAIT_HEADER,
        IN_LENGTH,
        IN_DATA,
        IN_TRAILER,
        DRAIN
    } parse_phase_t;

    typedef enum logic [1:0] {
        WORD_OPEN,
        WORD_GOOD,
        WORD_BAD
    } word_status_t;

    typedef struct packed {
        logic [7:0] value;
        logic       known;
        lpfd_item_t result;
    } stim_row_t;

    localparam lpfd_item_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  field_number;
    logic        last_in_field;
    logic [2:0]  error_code;
    logic [4:0]  field_total;
    logic [23:0] packet_length;

    logic       cur_known = 1'b0;
    lpfd_item_t cur_known_res = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int bytes_fed = 0;
    int results_checked = 0;
    int packets_accepted = 0;
    int packets_rejected = 0;

    stim_row_t  stim [$];
    lpfd_item_t parsed_items [$];
    lpfd_item_t predicted;
    lpfd_item_t want;
    bit         got;

    parse_phase_t phase_m;
    logic [1:0]   wpos;
    logic [31:0]  wbuf;
    logic [23:0]  total_m;
    logic [23:0]  pos_m;
    logic [23:0]  remain_m;
    logic [4:0]   nfields_m;
    logic [2:0]   err_m;

    stim_row_t opening_rows [63] = '{
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_BAD_WORD, 5'd0, 24'd0}},
        '{8'h05, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_BAD_WORD, 5'd0, 24'd5}},
        '{8'h11, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h04, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{KIND_EMPTY, 8'h00, 4'd0, 1'b0, ERR_NONE, 5'd0, 24'd0}},
        '{8'h05, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{KIND_BYTE, 8'hFF, 4'd1, 1'b1, ERR_NONE, 5'd0, 24'd0}},
        '{8'h11, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{KIND_ACCEPT, 8'h00, 4'd0, 1'b0, ERR_NONE, 5'd2, 24'd17}},
        '{8'h0C, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h07, 1'b0, NO_RES},
        '{8'hAA, 1'b0, NO_RES}, '{8'h55, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_BAD_WORD, 5'd0, 24'd12}},
        '{8'h0A, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h09, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h5A, 1'b0, NO_RES},
        '{8'hA5, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_OVERRUN, 5'd0, 24'd10}},
        '{8'h08, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h09, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_TRAILER, 5'd0, 24'd8}},
        '{8'h08, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h02, 1'b0, NO_RES},
        '{8'h08, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h04, 1'b1, '{KIND_REJECT, 8'h00, 4'd0, 1'b0, ERR_BAD_WORD, 5'd0, 24'd8}}
    };

    length_prefixed_field_deframer #(
        .LEN_BYTES(LEN_BYTES),
        .MAX_FIELDS(MAX_FIELDS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .payload_byte(payload_byte),
        .field_number(field_number),
        .last_in_field(last_in_field),
        .error_code(error_code),
        .field_total(field_total),
        .packet_length(packet_length)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    function automatic void clear_parse();
        phase_m = AWAIT_HEADER;
        wpos = '0;
        wbuf = '0;
        total_m = '0;
        pos_m = '0;
        remain_m = '0;
        nfields_m = '0;
        err_m = ERR_NONE;
    endfunction

    function automatic word_status_t collect_word(logic [7:0] b, output logic [23:0] val);
        val = '0;
        wbuf[8*wpos +: 8] = b;
        if (wpos + 1 < LEN_BYTES)
        begin
            wpos = wpos + 1'b1;
            return WORD_OPEN;
        end
        wpos = '0;
        if (b > LEN_BYTES - 1)
        begin
            wbuf = '0;
            return WORD_BAD;
        end
        for (int i = 0; i < LEN_BYTES - 1; i++)
            if (i < b)
                val[8*i +: 8] = wbuf[8*i +: 8];
        wbuf = '0;
        return WORD_GOOD;
    endfunction

    function automatic lpfd_item_t end_packet(logic [2:0] err, logic [23:0] plen);
        lpfd_item_t r;
        r = '0;
        r.kind = (err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
        r.err = err;
        r.ftot = nfields_m;
        r.plen = plen;
        clear_parse();
        return r;
    endfunction

    function automatic void after_field();
        if (pos_m < total_m - LEN_BYTES)
        begin
            if (nfields_m >= MAX_FIELDS)
            begin
                err_m = ERR_TOO_MANY;
                phase_m = DRAIN;
            end
            else
                phase_m = IN_LENGTH;
        end
        else
            phase_m = IN_TRAILER;
    endfunction

    function automatic bit parse_byte(logic [7:0] b, output lpfd_item_t res);
        logic [23:0]  val;
        word_status_t st;
        res = '0;
        pos_m = pos_m + 1'b1;
        case (phase_m)
            AWAIT_HEADER:
            begin
                st = collect_word(b, val);
                if (st == WORD_OPEN)
                    return 1'b0;
                if (st == WORD_BAD)
                begin
                    res = end_packet(ERR_BAD_WORD, '0);
                    return 1'b1;
                end
                total_m = val;
                if (val < 2 * LEN_BYTES)
                begin
                    res = end_packet(ERR_BAD_WORD, val);
                    return 1'b1;
                end
                after_field();
                return 1'b0;
            end
            IN_LENGTH:
            begin
                st = collect_word(b, val);
                if (st == WORD_OPEN)
                    return 1'b0;
                if (st == WORD_BAD || val < LEN_BYTES)
                begin
                    err_m = ERR_BAD_WORD;
                    phase_m = DRAIN;
                end
                else if ({8'h00, pos_m} + {8'h00, val} - LEN_BYTES >
                         {8'h00, total_m} - LEN_BYTES)
                begin
                    err_m = ERR_OVERRUN;
                    phase_m = DRAIN;
                end
                else if (val == LEN_BYTES)
                begin
                    res.kind = KIND_EMPTY;
                    res.fnum = nfields_m[3:0];
                    nfields_m = nfields_m + 1'b1;
                    after_field();
                    return 1'b1;
                end
                else
                begin
                    remain_m = 24'(val - LEN_BYTES);
                    phase_m = IN_DATA;
                    return 1'b0;
                end
                if (pos_m >= total_m)
                begin
                    res = end_packet(err_m, total_m);
                    return 1'b1;
                end
                return 1'b0;
            end
            IN_DATA:
            begin
                remain_m = remain_m - 1'b1;
                res.kind = KIND_BYTE;
                res.data = b;
                res.fnum = nfields_m[3:0];
                if (remain_m == '0)
                begin
                    res.last = 1'b1;
                    nfields_m = nfields_m + 1'b1;
                    after_field();
                end
                return 1'b1;
            end
            IN_TRAILER:
            begin
                st = collect_word(b, val);
                if (st == WORD_OPEN)
                    return 1'b0;
                if (st == WORD_BAD)
                    res = end_packet(ERR_BAD_WORD, total_m);
                else
                    res = end_packet((val == total_m) ? ERR_NONE : ERR_TRAILER, total_m);
                return 1'b1;
            end
            DRAIN:
            begin
                if (pos_m >= total_m)
                begin
                    res = end_packet(err_m, total_m);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                clear_parse();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.value = b;
        stim.push_back(row);
    endfunction

    function automatic void queue_word(logic [23:0] v, logic [7:0] cnt);
        for (int i = 0; i < LEN_BYTES - 1; i++)
            queue_byte((i < cnt) ? v[8*i +: 8] : 8'($urandom));
        queue_byte(cnt);
    endfunction

    function automatic int bytes_needed(logic [23:0] v);
        if (v == '0)
            return 0;
        if (v < 24'h000100)
            return 1;
        if (v < 24'h010000)
            return 2;
        return 3;
    endfunction

    function automatic void queue_good_word(logic [23:0] v);
        queue_word(v, 8'($urandom_range(bytes_needed(v), LEN_BYTES - 1)));
    endfunction

    function automatic void make_packet();
        int mode;
        int nf;
        int total;
        int bad_at;
        int pick;
        int lens [$];
        mode = $urandom_range(0, 99);
        if (mode >= 90)
        begin
            if ($urandom_range(0, 1) == 1)
                queue_word(24'($urandom), 8'($urandom_range(LEN_BYTES, 255)));
            else
                queue_good_word(24'($urandom_range(0, 2 * LEN_BYTES - 1)));
            return;
        end
        if (mode >= 80)
        begin
            // valid header, random body
            total = $urandom_range(2 * LEN_BYTES, 40);
            queue_good_word(24'(total));
            repeat (total - LEN_BYTES)
                queue_byte(8'($urandom));
            return;
        end
        if (mode < 8)
            nf = MAX_FIELDS + 1;
        else if (mode >= 60)
            nf = $urandom_range(1, 4);
        else if ($urandom_range(0, 19) == 0)
            nf = MAX_FIELDS;
        else
            nf = $urandom_range(0, 4);
        total = 2 * LEN_BYTES;
        for (int k = 0; k < nf; k++)
        begin
            if (nf > 4)
                lens.push_back($urandom_range(0, 2));
            else if ($urandom_range(0, 9) == 0)
                lens.push_back($urandom_range(0, 40));
            else
                lens.push_back($urandom_range(0, 6));
            total += LEN_BYTES + lens[k];
        end
        bad_at = (mode >= 60) ? $urandom_range(0, nf - 1) : -1;
        queue_good_word(24'(total));
        for (int k = 0; k < nf; k++)
        begin
            if (k == bad_at)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    queue_word(24'($urandom), 8'($urandom_range(LEN_BYTES, 255)));
                else if (pick == 1)
                    queue_good_word(24'($urandom_range(0, LEN_BYTES - 1)));
                else
                    queue_good_word(24'($urandom_range(24'hFFFFFF, total)));
            end
            else
                queue_good_word(24'(LEN_BYTES + lens[k]));
            repeat (lens[k])
                queue_byte(8'($urandom));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            queue_word(24'(total), 8'($urandom_range(LEN_BYTES, 255)));
        else if (pick == 1)
            queue_good_word(24'(total) ^ (24'd1 << $urandom_range(0, 7)));
        else
            queue_good_word(24'(total));
    endfunction

    task automatic flag_error(string msg);
        if (error_count < 40)
            $display("%0t ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [23:0] got_v, logic [23:0] want_v);
        if (got_v !== want_v)
            flag_error($sformatf("%s is %0h, want %0h", name, got_v, want_v));
    endtask

    task automatic feed_stream();
        stim_row_t row;
        while (stim.size() > 0 || in_valid)
        begin
            @(posedge clk);
            if (!in_valid || !in_stall)
            begin
                if (stim.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    row = stim.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= row.value;
                    cur_known <= row.known;
                    cur_known_res <= row.result;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (parsed_items.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (parsed_items.size() > 0)
        begin
            flag_error($sformatf("%0d results never arrived", parsed_items.size()));
            parsed_items.delete();
        end
    endtask

    // predict on each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            bytes_fed++;
            got = parse_byte(data_byte, predicted);
            if (cur_known)
                predicted = cur_known_res;
            if (got || cur_known)
                parsed_items.push_back(predicted);
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // compare each accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (parsed_items.size() == 0)
                flag_error($sformatf("result kind %0d with nothing pending", kind));
            else
            begin
                want = parsed_items.pop_front();
                if (want.kind == KIND_ACCEPT)
                    packets_accepted++;
                if (want.kind == KIND_REJECT)
                    packets_rejected++;
                check_field("kind", 24'(kind), 24'(want.kind));
                check_field("payload_byte", 24'(payload_byte), 24'(want.data));
                check_field("field_number", 24'(field_number), 24'(want.fnum));
                check_field("last_in_field", 24'(last_in_field), 24'(want.last));
                check_field("error_code", 24'(error_code), 24'(want.err));
                check_field("field_total", 24'(field_total), 24'(want.ftot));
                check_field("packet_length", packet_length, want.plen);
            end
        end
    end

    initial
    begin
        clear_parse();
        foreach (opening_rows[i])
            stim.push_back(opening_rows[i]);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int r = 0; r < ROUNDS; r++)
        begin
            send_idle_pct = SEND_IDLE[r];
            stall_pct = RECV_STALL[r];
            while (stim.size() < BYTES_PER_ROUND)
                make_packet();
            feed_stream();
            drain_results();
        end
        stall_pct = 0;
        repeat (16) @(posedge clk);
        $display("Fed %0d bytes over four pacing rounds; checked %0d results.",
                 bytes_fed, results_checked);
        $display("Packets closed: %0d accepted, %0d rejected; %0d mismatches.",
                 packets_accepted, packets_rejected, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results pending.", parsed_items.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
